/* rtl/ptet_pkg.sv */
package ptet_pkg;

  localparam int DEF_SLOTS    = 32;
  localparam int DEF_TAG_BITS = 16;

  localparam int REQ_W     = 3;
  localparam int KIND_W    = 3;
  localparam int ID_W      = 32;
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 31;
  localparam int OUT_TAG_W = 16;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SCHEDULE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RUN      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] RES_SCHED    = 3'd0;
  localparam logic [KIND_W-1:0] RES_CANCEL   = 3'd1;
  localparam logic [KIND_W-1:0] RES_FIRE     = 3'd2;
  localparam logic [KIND_W-1:0] RES_RUN_DONE = 3'd3;
  localparam logic [KIND_W-1:0] RES_DUE      = 3'd4;
  localparam logic [KIND_W-1:0] RES_TICK     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 success;
    logic [ID_W-1:0]      task_id;
    logic [OUT_TAG_W-1:0] tag;
    logic                 any_due;
    logic                 last;
  } res_t;

endpackage

/* rtl/ptet_ram.sv */
module ptet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ptet_ctrl.sv */
module ptet_ctrl import ptet_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [PERIOD_W-1:0]  first_delay,
  input  logic [PERIOD_W-1:0]  period_ticks,
  input  logic [OUT_TAG_W-1:0] task_tag,
  input  logic [ID_W-1:0]      cancel_id,
  input  logic                 out_free,
  output logic                 res_valid,
  output res_t                 res
);

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = ID_W + TIME_W + PERIOD_W + TAG_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t state, state_next;

  logic [REQ_W-1:0]    op;
  logic [PERIOD_W-1:0] delay_q;
  logic [PERIOD_W-1:0] period_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [ID_W-1:0]     cid_q;
  logic [IDX_W-1:0]    idx;
  logic [SLOTS-1:0]    active;
  logic [ID_W-1:0]     id_counter;
  logic [TIME_W-1:0]   tick_count;

  logic [KIND_W-1:0] fin_kind;
  logic              fin_success;
  logic [ID_W-1:0]   fin_id;
  logic              fin_any;

  logic [TAG_BITS-1:0]  tag_in;
  logic [OUT_TAG_W-1:0] tag_out;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [ID_W-1:0]     rd_id;
  logic [TIME_W-1:0]   rd_due;
  logic [PERIOD_W-1:0] rd_period;
  logic [TAG_BITS-1:0] rd_tag;

  logic [TIME_W-1:0]   due_diff;
  logic                slot_active;
  logic                slot_due;
  logic                hit;
  logic                fire;
  logic                stall;
  logic                step_done;
  logic                is_last;
  logic [PERIOD_W-1:0] delay_eff;
  logic [ID_W-1:0]     id_inc;

  // Tag width adaptation between the 16-bit ports and the stored tag.
  if (TAG_BITS > OUT_TAG_W) begin : g_tag_wide
    assign tag_in  = {{(TAG_BITS - OUT_TAG_W){1'b0}}, task_tag};
    assign tag_out = rd_tag[OUT_TAG_W-1:0];
  end else if (TAG_BITS == OUT_TAG_W) begin : g_tag_same
    assign tag_in  = task_tag;
    assign tag_out = rd_tag;
  end else begin : g_tag_narrow
    assign tag_in  = task_tag[TAG_BITS-1:0];
    assign tag_out = {{(OUT_TAG_W - TAG_BITS){1'b0}}, rd_tag};
  end

  ptet_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_id     = ram_rdata[ENTRY_W-1 -: ID_W];
  assign rd_due    = ram_rdata[TAG_BITS + PERIOD_W +: TIME_W];
  assign rd_period = ram_rdata[TAG_BITS +: PERIOD_W];
  assign rd_tag    = ram_rdata[TAG_BITS-1:0];

  assign due_diff    = tick_count - rd_due;
  assign slot_active = active[idx];
  assign slot_due    = ~due_diff[TIME_W-1];
  assign is_last     = (idx == LAST_IDX);
  assign delay_eff   = (delay_q == '0) ? PERIOD_W'(1) : delay_q;
  assign id_inc      = id_counter + ID_W'(1);

  always_comb begin
    unique case (op)
      REQ_SCHEDULE: hit = ~slot_active;
      REQ_CANCEL:   hit = slot_active && (rd_id == cid_q);
      REQ_RUN,
      REQ_QUERY:    hit = slot_active && slot_due;
      default:      hit = 1'b0;
    endcase
  end

  assign fire      = (state == ST_SCAN) && (op == REQ_RUN) && hit;
  assign stall     = fire && !out_free;
  assign step_done = !stall && ((hit && (op != REQ_RUN)) || is_last);

  always_comb begin
    if (op == REQ_SCHEDULE) begin
      ram_wdata = {id_counter, tick_count + {1'b0, delay_eff}, period_q, tag_q};
    end else begin
      ram_wdata = {rd_id, tick_count + {1'b0, rd_period}, rd_period, rd_tag};
    end
  end

  assign ram_we = (state == ST_SCAN) && !stall && hit &&
                  ((op == REQ_SCHEDULE) || ((op == REQ_RUN) && (rd_period != '0)));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            REQ_SCHEDULE: state_next = (tag_in == '0) ? ST_DONE : ST_SCAN;
            REQ_CANCEL:   state_next = (cancel_id == '0) ? ST_DONE : ST_SCAN;
            REQ_TICK:     state_next = ST_DONE;
            REQ_RUN,
            REQ_QUERY:    state_next = ST_SCAN;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (step_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory read address.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    ram_raddr = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        res_valid   = fire;
        res.kind    = RES_FIRE;
        res.task_id = rd_id;
        res.tag     = tag_out;
        if (stall) begin
          ram_raddr = idx;
        end else if (!is_last) begin
          ram_raddr = idx + IDX_W'(1);
        end
      end
      ST_DONE: begin
        res_valid   = 1'b1;
        res.kind    = fin_kind;
        res.success = fin_success;
        res.task_id = fin_id;
        res.any_due = fin_any;
        res.last    = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      id_counter <= ID_W'(1);
      tick_count <= '0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_IDLE) && in_valid) begin
        op          <= req_type;
        delay_q     <= first_delay;
        period_q    <= period_ticks;
        tag_q       <= tag_in;
        cid_q       <= cancel_id;
        idx         <= '0;
        fin_success <= 1'b0;
        fin_id      <= '0;
        fin_any     <= 1'b0;
        case (req_type)
          REQ_SCHEDULE: fin_kind <= RES_SCHED;
          REQ_CANCEL:   fin_kind <= RES_CANCEL;
          REQ_RUN:      fin_kind <= RES_RUN_DONE;
          REQ_QUERY:    fin_kind <= RES_DUE;
          default:      fin_kind <= RES_TICK;
        endcase
        if (req_type == REQ_TICK) begin
          tick_count <= tick_count + TIME_W'(1);
        end
      end else if ((state == ST_SCAN) && !stall) begin
        idx <= idx + IDX_W'(1);
        if (hit) begin
          case (op)
            REQ_SCHEDULE: begin
              active[idx] <= 1'b1;
              id_counter  <= (id_inc == '0) ? ID_W'(1) : id_inc;
              fin_success <= 1'b1;
              fin_id      <= id_counter;
            end
            REQ_CANCEL: begin
              active[idx] <= 1'b0;
              fin_success <= 1'b1;
            end
            REQ_QUERY: begin
              fin_any <= 1'b1;
            end
            REQ_RUN: begin
              if (rd_period == '0) begin
                active[idx] <= 1'b0;
              end
            end
            default: begin
              fin_any <= fin_any;
            end
          endcase
        end
      end
    end
  end

endmodule

/* rtl/periodic_timer_event_table_unit.sv */
// Periodic timer event table: a table of SLOTS one-shot or periodic timers
// kept against a 32-bit tick counter that only tick requests advance.
// Requests enter on the input channel (in_valid / in_ready) as one transaction
// each: schedule, cancel, tick, run due and query due. Results leave on the
// output channel (out_valid / out_ready); every request except an unknown code
// produces one or more result transactions and its final one carries last.
// The entry fields (id, due time, period, tag) live in one synchronous RAM;
// the active flags are flip-flops. Schedule, cancel, run due and query walk the
// slots in order, one slot per cycle unless the output stalls, reading the RAM
// one slot ahead and writing back the slot under inspection. A request is
// accepted, scanned slot by slot, and then posts its final result. Schedule,
// cancel and query stop at the first hit; tick, a zero tag and a zero cancel
// id skip the scan. A run due pass does not pause for a fired timer unless
// the output is stalled.
// Results pass through an output register, so a new request is accepted while
// the previous final result still waits there. When the receiver stalls, the
// scan holds on the current slot until the output register frees up.
// Reset clears all active flags, sets the id counter to 1 and the tick count
// to 0; no clearing pass is needed.
module periodic_timer_event_table_unit import ptet_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [PERIOD_W-1:0]  first_delay,
  input  logic [PERIOD_W-1:0]  period_ticks,
  input  logic [OUT_TAG_W-1:0] task_tag,
  input  logic [ID_W-1:0]      cancel_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    result_kind,
  output logic                 success,
  output logic [ID_W-1:0]      task_id,
  output logic [OUT_TAG_W-1:0] fired_tag,
  output logic                 any_due,
  output logic                 last
);

  logic out_free;
  logic res_valid;
  res_t res;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;

  ptet_ctrl #(
    .SLOTS   (SLOTS),
    .TAG_BITS(TAG_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .first_delay (first_delay),
    .period_ticks(period_ticks),
    .task_tag    (task_tag),
    .cancel_id   (cancel_id),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register: control bit is reset, the payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      result_kind <= res.kind;
      success     <= res.success;
      task_id     <= res.task_id;
      fired_tag   <= res.tag;
      any_due     <= res.any_due;
      last        <= res.last;
    end
  end

`ifndef SYNTHESIS
  // A recognized request keeps the input closed in the cycle after it is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type == REQ_SCHEDULE || req_type == REQ_CANCEL ||
    req_type == REQ_TICK || req_type == REQ_RUN || req_type == REQ_QUERY)
    |=> !in_ready)
    else $error("input accepted again right after a recognized request");

  // A fire result is never the final result of a request.
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RES_FIRE) |-> !last && !success)
    else $error("fire result marked last or successful");

  // Every non-fire result closes its request.
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != RES_FIRE) |-> last)
    else $error("final result without last");

  // A successful schedule never hands out id zero.
  a_sched_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RES_SCHED) && success |-> task_id != '0)
    else $error("schedule succeeded with id zero");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ptet_pkg::*;

  localparam int SLOTS       = DEF_SLOTS;
  localparam int HOLD_CYCLES = 300;   // length of the long receiver hold-off
  localparam int QUIET_LIMIT = 4000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 40;    // a little more than one full slot scan

  // Request codes the block does not decode; they must produce no result.
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  // Tracks the timer table as the block should hold it and keeps the results
  // still owed by the block, oldest first.
  class timer_table_tracker;
    bit                 armed       [SLOTS];
    bit [ID_W-1:0]      slot_id     [SLOTS];
    bit [TIME_W-1:0]    slot_due    [SLOTS];
    bit [PERIOD_W-1:0]  slot_period [SLOTS];
    bit [OUT_TAG_W-1:0] slot_tag    [SLOTS];
    bit [ID_W-1:0]      next_id;
    bit [TIME_W-1:0]    now;
    res_t               owed [$];
    int                 errors;

    function new();
      foreach (armed[i]) armed[i] = 1'b0;
      next_id = 1;
      now     = '0;
      errors  = 0;
    endfunction

    // Due when (now - when) is not negative as a two's complement number.
    function bit is_due(bit [TIME_W-1:0] when);
      bit [TIME_W-1:0] diff;
      diff = now - when;
      return !diff[TIME_W-1];
    endfunction

    function void owe(logic [KIND_W-1:0] kind, bit ok, bit [ID_W-1:0] id,
                      bit [OUT_TAG_W-1:0] tg, bit due, bit fin);
      res_t r;
      r.kind    = kind;
      r.success = ok;
      r.task_id = id;
      r.tag     = tg;
      r.any_due = due;
      r.last    = fin;
      owed.push_back(r);
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [PERIOD_W-1:0] dly,
                               logic [PERIOD_W-1:0] prd, logic [OUT_TAG_W-1:0] tg,
                               logic [ID_W-1:0] cid);
      int                slot;
      bit                hit;
      bit [PERIOD_W-1:0] first_wait;
      slot = -1;
      hit  = 1'b0;
      case (req)
        REQ_SCHEDULE: begin
          if (tg != '0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!armed[i]) begin
                slot = i;
                break;
              end
            end
          end
          if (slot >= 0) begin
            first_wait        = (dly == '0) ? PERIOD_W'(1) : dly;
            armed[slot]       = 1'b1;
            slot_id[slot]     = next_id;
            slot_due[slot]    = now + first_wait;
            slot_period[slot] = prd;
            slot_tag[slot]    = tg;
            owe(RES_SCHED, 1'b1, next_id, '0, 1'b0, 1'b1);
            next_id++;
            if (next_id == '0) next_id = 1;
          end else begin
            owe(RES_SCHED, 1'b0, '0, '0, 1'b0, 1'b1);
          end
        end
        REQ_CANCEL: begin
          if (cid != '0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (armed[i] && slot_id[i] == cid) begin
                armed[i] = 1'b0;
                hit      = 1'b1;
                break;
              end
            end
          end
          owe(RES_CANCEL, hit, '0, '0, 1'b0, 1'b1);
        end
        REQ_TICK: begin
          now++;
          owe(RES_TICK, 1'b0, '0, '0, 1'b0, 1'b1);
        end
        REQ_RUN: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i] && is_due(slot_due[i])) begin
              owe(RES_FIRE, 1'b0, slot_id[i], slot_tag[i], 1'b0, 1'b0);
              if (slot_period[i] == '0) armed[i] = 1'b0;
              else slot_due[i] = now + slot_period[i];
            end
          end
          owe(RES_RUN_DONE, 1'b0, '0, '0, 1'b0, 1'b1);
        end
        REQ_QUERY: begin
          for (int i = 0; i < SLOTS; i++) hit |= armed[i] && is_due(slot_due[i]);
          owe(RES_DUE, 1'b0, '0, '0, hit, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        $error("result_kind %0d arrived with nothing expected", got.kind);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.success !== want.success) begin
        $error("success: expected %0d, actual %0d", want.success, got.success);
        errors++;
      end
      if (got.task_id !== want.task_id) begin
        $error("task_id: expected %0h, actual %0h", want.task_id, got.task_id);
        errors++;
      end
      if (got.tag !== want.tag) begin
        $error("fired_tag: expected %0h, actual %0h", want.tag, got.tag);
        errors++;
      end
      if (got.any_due !== want.any_due) begin
        $error("any_due: expected %0d, actual %0d", want.any_due, got.any_due);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    // Id of a random armed timer, or zero when the table is empty.
    function bit [ID_W-1:0] pick_live_id();
      bit [ID_W-1:0] live [$];
      foreach (armed[i]) if (armed[i]) live.push_back(slot_id[i]);
      if (live.size() == 0) return '0;
      return live[$urandom_range(live.size() - 1)];
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [REQ_W-1:0]     req_type;
  logic [PERIOD_W-1:0]  first_delay;
  logic [PERIOD_W-1:0]  period_ticks;
  logic [OUT_TAG_W-1:0] task_tag;
  logic [ID_W-1:0]      cancel_id;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    result_kind;
  logic                 success;
  logic [ID_W-1:0]      task_id;
  logic [OUT_TAG_W-1:0] fired_tag;
  logic                 any_due;
  logic                 last;

  timer_table_tracker table_state;

  // Idle and stall rates in percent, changed by the main sequence per phase.
  int send_idle_pct;
  int stall_pct;

  // The main sequence bumps hold_asks to ask for one long receiver hold-off.
  // The receiver notices the change and counts the hold-off down by itself.
  int hold_asks;
  int hold_seen;
  int hold_left;

  int quiet_cycles;

  periodic_timer_event_table_unit #(
    .SLOTS   (SLOTS),
    .TAG_BITS(DEF_TAG_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .first_delay (first_delay),
    .period_ticks(period_ticks),
    .task_tag    (task_tag),
    .cancel_id   (cancel_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .success     (success),
    .task_id     (task_id),
    .fired_tag   (fired_tag),
    .any_due     (any_due),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one request and returns at the edge where its transaction is
  // accepted. The tracker is updated right there, so a request that is built
  // afterwards (a cancel of a live id, say) sees the table as it now stands.
  // Valid is lowered only when an idle gap is taken; back-to-back requests
  // keep valid high and only swap the payload.
  task automatic send_request(logic [REQ_W-1:0] req, logic [PERIOD_W-1:0] dly,
                              logic [PERIOD_W-1:0] prd, logic [OUT_TAG_W-1:0] tg,
                              logic [ID_W-1:0] cid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    first_delay  <= dly;
    period_ticks <= prd;
    task_tag     <= tg;
    cancel_id    <= cid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_state.note_request(req, dly, prd, tg, cid);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (table_state.owed.size() != 0);
  endtask

  // One random request. Delays and periods are mostly short so that timers
  // really fire and rearm, with full-width values now and then so that every
  // bit toggles and far-future due times are exercised. Most cancels name a
  // timer that is armed right now; the rest use random or zero ids.
  task automatic random_request();
    int                   pick;
    int                   roll;
    logic [PERIOD_W-1:0]  dly;
    logic [PERIOD_W-1:0]  prd;
    logic [OUT_TAG_W-1:0] tg;
    logic [ID_W-1:0]      cid;
    pick = $urandom_range(99);
    dly  = ($urandom_range(9) < 7) ? PERIOD_W'($urandom_range(6)) : PERIOD_W'($urandom());
    roll = $urandom_range(9);
    if (roll < 4) prd = '0;
    else if (roll < 8) prd = PERIOD_W'($urandom_range(8, 1));
    else prd = PERIOD_W'($urandom());
    tg  = ($urandom_range(29) == 0) ? '0 : OUT_TAG_W'($urandom_range(65535, 1));
    cid = ($urandom_range(9) < 7) ? table_state.pick_live_id() : ID_W'($urandom());
    if (pick < 35) send_request(REQ_SCHEDULE, dly, prd, tg, cid);
    else if (pick < 47) send_request(REQ_CANCEL, dly, prd, tg, cid);
    else if (pick < 72) send_request(REQ_TICK, dly, prd, tg, cid);
    else if (pick < 87) send_request(REQ_RUN, dly, prd, tg, cid);
    else if (pick < 97) send_request(REQ_QUERY, dly, prd, tg, cid);
    else send_request(REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO)),
                      dly, prd, tg, cid);
  endtask

  // Result side: checks every accepted result transaction and picks the next
  // value of ready, either from the stall rate or from a pending hold-off.
  initial begin
    out_ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        res_t got;
        got.kind    = result_kind;
        got.success = success;
        got.task_id = task_id;
        got.tag     = fired_tag;
        got.any_due = any_due;
        got.last    = last;
        table_state.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: a long run of cycles in which neither channel completes a
  // transaction means the block has hung.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    req_type     <= REQ_SCHEDULE;
    first_delay  <= '0;
    period_ticks <= '0;
    task_tag     <= '0;
    cancel_id    <= '0;
    hold_asks    <= 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    table_state   = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. An empty table first, then a schedule rejected for its
    // zero tag and the field extremes, cancels that must miss (id zero,
    // unknown id), a due time that is not yet reached, a one-shot timer that
    // fires and frees its slot, a periodic one that rearms, a repeated cancel,
    // and undecoded request codes that must stay silent.
    send_request(REQ_QUERY, '0, '0, '0, '0);
    send_request(REQ_RUN, '0, '0, '0, '0);
    send_request(REQ_SCHEDULE, 31'd5, 31'd0, 16'h0000, '0);
    send_request(REQ_SCHEDULE, 31'd0, 31'd0, 16'hFFFF, '0);
    send_request(REQ_SCHEDULE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h0001, '1);
    send_request(REQ_SCHEDULE, 31'd2, 31'd3, 16'h5A5A, '0);
    send_request(REQ_CANCEL, '1, '1, '1, 32'h0000_0000);
    send_request(REQ_CANCEL, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(REQ_QUERY, '0, '0, '0, '0);
    send_request(REQ_TICK, '0, '0, '0, '0);
    send_request(REQ_QUERY, '0, '0, '0, '0);
    send_request(REQ_RUN, '0, '0, '0, '0);
    send_request(REQ_TICK, '0, '0, '0, '0);
    send_request(REQ_RUN, '0, '0, '0, '0);
    send_request(REQ_CANCEL, '0, '0, '0, 32'd3);
    send_request(REQ_CANCEL, '0, '0, '0, 32'd3);
    send_request(REQ_UNUSED_LO, '1, '1, '1, '1);
    send_request(REQ_UNUSED_HI, '0, '0, '0, '0);
    send_request(REQ_QUERY, '0, '0, '0, '0);
    send_request(REQ_CANCEL, '0, '0, '0, 32'd2);
    send_request(REQ_RUN, '0, '0, '0, '0);
    settle();

    // Fill the whole table while the receiver holds off, so the output
    // register and then the input side back up. The two extra schedules hit
    // a full table. After two ticks every timer is due, so the run due
    // request fires all of them, which is the longest result burst.
    hold_asks <= hold_asks + 1;
    repeat (SLOTS + 2)
      send_request(REQ_SCHEDULE, PERIOD_W'($urandom_range(2)),
                   ($urandom_range(1) == 1) ? PERIOD_W'($urandom_range(4, 1)) : '0,
                   OUT_TAG_W'($urandom_range(65535, 1)), '0);
    send_request(REQ_TICK, '0, '0, '0, '0);
    send_request(REQ_TICK, '0, '0, '0, '0);
    send_request(REQ_RUN, '0, '0, '0, '0);
    send_request(REQ_QUERY, '0, '0, '0, '0);
    settle();

    // Random part in four phases of idling: none, a slow sender, a slow
    // receiver, and light idling on both sides.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      repeat (50) random_request();
      settle();
    end

    // Anything that shows up now is a result nobody asked for.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (table_state.errors == 0 && table_state.owed.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
